FILE: sv/particle_link_contact_unit_macros.svh
// Assertion macros shared by the checker of the contact unit.
// All of them sample on aclk; the first two are disabled while aresetn is low.
`ifndef PARTICLE_LINK_CONTACT_UNIT_MACROS_SVH
`define PARTICLE_LINK_CONTACT_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define PLC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("contact unit check failed");

// Next-cycle implication, quiet during reset.
`define PLC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("contact unit check failed");

// Next-cycle implication that also holds across reset.
`define PLC_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("contact unit reset check failed");

`endif

FILE: sv/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared constants and types of the particle link contact unit.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int CFG_IDX_BITS = 2;
    localparam int PEN_BITS     = 25;
    localparam int REST_BITS    = 16;
    localparam int NORM_BITS    = 16;
    localparam int NORM_QBITS   = 15;
    localparam int NORM_ONE     = 16384;

    localparam logic [CFG_IDX_BITS-1:0] REG_LINK_KIND     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REST_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOUNCE_FACTOR = 2'd2;

    localparam logic [PEN_BITS-1:0] PEN_MAX = {PEN_BITS{1'b1}};

    typedef struct packed {
        logic                        has_contact;
        logic signed [NORM_BITS-1:0] normal_x;
        logic signed [NORM_BITS-1:0] normal_y;
        logic signed [NORM_BITS-1:0] normal_z;
        logic [PEN_BITS-1:0]         penetration;
        logic [REST_BITS-1:0]        restitution;
    } res_t;

endpackage

FILE: sv/plc_sqrt.sv
// ----------------------------------------------------------------------------
// plc_sqrt
// Pipelined floor square root, one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module plc_sqrt #(
    parameter int DW = 25
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [2*DW-1:0]   sum,
    output logic [DW-1:0]     root
);

    localparam int SW = 2 * DW;

    logic [SW-1:0] rem_reg  [0:DW-1];
    logic [DW-1:0] root_reg [0:DW-1];

    for (genvar j = 0; j < DW; j++) begin : g_stage
        localparam int B = DW - 1 - j;
        logic [SW:0]   rin;
        logic [DW-1:0] qin;
        logic [SW:0]   trial;
        logic [SW-1:0] rem_next;
        logic [DW-1:0] root_next;

        if (j == 0) begin : g_first
            assign rin = {1'b0, sum};
            assign qin = '0;
        end else begin : g_rest
            assign rin = {1'b0, rem_reg[j-1]};
            assign qin = root_reg[j-1];
        end

        // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
        assign trial = ((SW+1)'(qin) << (B + 1)) + ((SW+1)'(1) << (2 * B));

        always_comb begin
            if (rin >= trial) begin
                rem_next  = SW'(rin - trial);
                root_next = qin | (DW'(1) << B);
            end else begin
                rem_next  = SW'(rin);
                root_next = qin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign root = root_reg[DW-1];

endmodule

FILE: sv/plc_div.sv
// ----------------------------------------------------------------------------
// plc_div
// Pipelined restoring divider for one normal component, one quotient bit per
// stage.
// ----------------------------------------------------------------------------
module plc_div #(
    parameter int DW = 25
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [DW+15:0]                      num,
    input  logic [DW-1:0]                       den,
    output logic [plc_pkg::NORM_QBITS-1:0]      quo
);

    localparam int QB = plc_pkg::NORM_QBITS;
    localparam int NW = DW + 16;

    logic [NW-1:0] rem_reg [0:QB-1];
    logic [DW-1:0] den_reg [0:QB-1];
    logic [QB-1:0] quo_reg [0:QB-1];

    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int B = QB - 1 - j;
        logic [NW-1:0] rin;
        logic [DW-1:0] din;
        logic [QB-1:0] qin;
        logic [NW-1:0] dd;

        if (j == 0) begin : g_first
            assign rin = num;
            assign din = den;
            assign qin = '0;
        end else begin : g_rest
            assign rin = rem_reg[j-1];
            assign din = den_reg[j-1];
            assign qin = quo_reg[j-1];
        end

        // The divisor is twice the distance, for rounding to nearest.
        assign dd = NW'({din, 1'b0}) << B;

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[j] <= din;
                if (rin >= dd) begin
                    rem_reg[j] <= rin - dd;
                    quo_reg[j] <= qin | (QB'(1) << B);
                end else begin
                    rem_reg[j] <= rin;
                    quo_reg[j] <= qin;
                end
            end
        end
    end

    assign quo = quo_reg[QB-1];

endmodule

FILE: sv/particle_link_contact_unit.sv
// ----------------------------------------------------------------------------
// particle_link_contact_unit
// Cable and rod contact generator for two linked particles, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: each input beat on the s_ channel carries the Q12.12 positions of the
// two particles of one link. Each beat yields exactly one result beat on the
// m_ channel: a contact flag, a Q1.14 unit normal, a Q13.12 penetration and a
// Q1.15 restitution, in input order.
// The cfg channel writes link_kind, rest_length and bounce_factor by index;
// it is always ready and should only be used while the pipeline is empty.
// From input beat to result beat an item passes three front stages, one stage per
// root bit, one compare stage, fifteen divider stages and the output register.
// Throughput is one beat per cycle while the receiver does not stall; the
// long square root and divider chains are split one bit per stage.
// Reset clears all valid bits and loads the register defaults (cable,
// length 1.0, restitution 0). When the receiver stalls, the output item moves
// into a skid register and s_ready drops in the next cycle, so no beat is
// lost or repeated; the pipeline resumes once the skid entry is taken.
// ----------------------------------------------------------------------------
module particle_link_contact_unit #(
    parameter int COORD_BITS = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [plc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [plc_pkg::PEN_BITS-1:0]           cfg_data,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [COORD_BITS-1:0]           s_first_x,
    input  logic signed [COORD_BITS-1:0]           s_first_y,
    input  logic signed [COORD_BITS-1:0]           s_first_z,
    input  logic signed [COORD_BITS-1:0]           s_second_x,
    input  logic signed [COORD_BITS-1:0]           s_second_y,
    input  logic signed [COORD_BITS-1:0]           s_second_z,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_has_contact,
    output logic signed [plc_pkg::NORM_BITS-1:0]   m_normal_x,
    output logic signed [plc_pkg::NORM_BITS-1:0]   m_normal_y,
    output logic signed [plc_pkg::NORM_BITS-1:0]   m_normal_z,
    output logic [plc_pkg::PEN_BITS-1:0]           m_penetration,
    output logic [plc_pkg::REST_BITS-1:0]          m_contact_restitution
);

    // Difference magnitudes and the distance both fit in COORD_BITS + 1 bits.
    localparam int DW     = COORD_BITS + 1;
    localparam int PB     = plc_pkg::PEN_BITS;
    localparam int QB     = plc_pkg::NORM_QBITS;
    localparam int PW     = ((DW > PB) ? DW : PB) + 1;
    localparam int K_CMP  = 3 + DW;
    localparam int K_OUT  = K_CMP + 1 + QB;
    localparam int NS     = K_OUT + 1;

    typedef struct packed {
        logic [2:0]    neg;
        logic [DW-1:0] mx;
        logic [DW-1:0] my;
        logic [DW-1:0] mz;
    } geo_t;

    typedef struct packed {
        logic          contact;
        logic          flip;
        logic          zero;
        logic [2:0]    neg;
        logic [PB-1:0] pen;
    } ctl_t;

    // Configuration registers.
    logic             link_kind_reg;
    logic [PB-1:0]    rest_length_reg;
    logic [plc_pkg::REST_BITS-1:0] bounce_factor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_kind_reg     <= 1'b0;
            rest_length_reg   <= PB'(4096);
            bounce_factor_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                plc_pkg::REG_LINK_KIND:     link_kind_reg     <= cfg_data[0];
                plc_pkg::REG_REST_LENGTH:   rest_length_reg   <= cfg_data;
                plc_pkg::REG_BOUNCE_FACTOR: bounce_factor_reg <=
                    cfg_data[plc_pkg::REST_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together unless the skid entry is occupied.
    logic          skid_full_reg;
    logic          en;
    logic [NS-1:0] v_reg;

    assign en      = !skid_full_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], s_valid};
        end
    end

    // Stage 0: coordinate differences as sign and magnitude.
    geo_t geo_reg [0:K_CMP];
    geo_t geo_next;
    logic signed [DW-1:0] dx, dy, dz;

    always_comb begin
        dx = DW'(s_second_x) - DW'(s_first_x);
        dy = DW'(s_second_y) - DW'(s_first_y);
        dz = DW'(s_second_z) - DW'(s_first_z);
        geo_next.neg = {dz[DW-1], dy[DW-1], dx[DW-1]};
        geo_next.mx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
        geo_next.my  = dy[DW-1] ? DW'(-dy) : DW'(dy);
        geo_next.mz  = dz[DW-1] ? DW'(-dz) : DW'(dz);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo_reg[0] <= geo_next;
        end
    end

    for (genvar k = 1; k <= K_CMP; k++) begin : g_geo
        always_ff @(posedge aclk) begin
            if (en) begin
                geo_reg[k] <= geo_reg[k-1];
            end
        end
    end

    // Stage 1: squares. Stage 2: their sum.
    logic [2*DW-1:0] sqx_reg, sqy_reg, sqz_reg, sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= geo_reg[0].mx * geo_reg[0].mx;
            sqy_reg <= geo_reg[0].my * geo_reg[0].my;
            sqz_reg <= geo_reg[0].mz * geo_reg[0].mz;
            sum_reg <= sqx_reg + sqy_reg + sqz_reg;
        end
    end

    // Stages 3 to K_CMP-1: square root, one bit per stage.
    logic [DW-1:0] root;

    plc_sqrt #(.DW(DW)) u_sqrt (
        .aclk (aclk),
        .en   (en),
        .sum  (sum_reg),
        .root (root)
    );

    // Compare stage: contact decision and penetration.
    ctl_t          ctl_reg [K_CMP:K_OUT-1];
    ctl_t          ctl_next;
    logic [DW-1:0] dist_reg;
    logic [PW-1:0] dist_w, rest_w, pen_w;

    always_comb begin
        dist_w           = PW'(root);
        rest_w           = PW'(rest_length_reg);
        ctl_next.neg     = geo_reg[K_CMP-1].neg;
        ctl_next.zero    = (root == '0);
        ctl_next.flip    = 1'b0;
        if (!link_kind_reg) begin
            ctl_next.contact = (dist_w >= rest_w);
            pen_w            = ctl_next.contact ? dist_w - rest_w : '0;
        end else begin
            ctl_next.contact = (dist_w != rest_w);
            if (dist_w > rest_w) begin
                pen_w = dist_w - rest_w;
            end else begin
                pen_w         = rest_w - dist_w;
                ctl_next.flip = 1'b1;
            end
        end
        ctl_next.pen = (pen_w > PW'(plc_pkg::PEN_MAX)) ? plc_pkg::PEN_MAX : PB'(pen_w);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg[K_CMP] <= ctl_next;
            dist_reg       <= root;
        end
    end

    for (genvar k = K_CMP + 1; k < K_OUT; k++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (en) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // Divider stages: round(mag * 16384 / dist) as floor((mag*32768 + dist) / (2*dist)).
    logic [QB-1:0] qx, qy, qz;

    plc_div #(.DW(DW)) u_div_x (
        .aclk (aclk), .en (en),
        .num  ((DW+16)'({geo_reg[K_CMP].mx, 15'd0}) + (DW+16)'(dist_reg)),
        .den  (dist_reg), .quo (qx)
    );
    plc_div #(.DW(DW)) u_div_y (
        .aclk (aclk), .en (en),
        .num  ((DW+16)'({geo_reg[K_CMP].my, 15'd0}) + (DW+16)'(dist_reg)),
        .den  (dist_reg), .quo (qy)
    );
    plc_div #(.DW(DW)) u_div_z (
        .aclk (aclk), .en (en),
        .num  ((DW+16)'({geo_reg[K_CMP].mz, 15'd0}) + (DW+16)'(dist_reg)),
        .den  (dist_reg), .quo (qz)
    );

    // Output stage: signs, clamping and zeroing of the no-contact and zero-distance cases.
    function automatic logic signed [plc_pkg::NORM_BITS-1:0] norm_fix(
        input logic [QB-1:0] q,
        input logic          neg,
        input logic          zero
    );
        logic [QB-1:0] qc;
        logic signed [plc_pkg::NORM_BITS-1:0] n;
        qc = (q > QB'(plc_pkg::NORM_ONE)) ? QB'(plc_pkg::NORM_ONE) : q;
        if (zero) begin
            qc = '0;
        end
        n = plc_pkg::NORM_BITS'(qc);
        return neg ? -n : n;
    endfunction

    ctl_t          ctl_o;
    plc_pkg::res_t res_next, out_reg, skid_reg;

    always_comb begin
        ctl_o    = ctl_reg[K_OUT-1];
        res_next = '0;
        if (ctl_o.contact) begin
            res_next.has_contact = 1'b1;
            res_next.normal_x    = norm_fix(qx, ctl_o.neg[0] ^ ctl_o.flip, ctl_o.zero);
            res_next.normal_y    = norm_fix(qy, ctl_o.neg[1] ^ ctl_o.flip, ctl_o.zero);
            res_next.normal_z    = norm_fix(qz, ctl_o.neg[2] ^ ctl_o.flip, ctl_o.zero);
            res_next.penetration = ctl_o.pen;
            res_next.restitution = link_kind_reg ? '0 : bounce_factor_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= res_next;
        end
    end

    // Skid entry: takes the output item when it is stalled and the pipe moves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            skid_full_reg <= !m_ready;
        end else begin
            skid_full_reg <= v_reg[NS-1] && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_full_reg && v_reg[NS-1] && !m_ready) begin
            skid_reg <= out_reg;
        end
    end

    plc_pkg::res_t res_o;

    assign res_o                 = skid_full_reg ? skid_reg : out_reg;
    assign m_valid               = skid_full_reg || v_reg[NS-1];
    assign m_has_contact         = res_o.has_contact;
    assign m_normal_x            = res_o.normal_x;
    assign m_normal_y            = res_o.normal_y;
    assign m_normal_z            = res_o.normal_z;
    assign m_penetration         = res_o.penetration;
    assign m_contact_restitution = res_o.restitution;

endmodule

FILE: sv/plc_checker.sv
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks of the contact unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "particle_link_contact_unit_macros.svh"

module plc_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic                                 m_has_contact,
    input logic signed [plc_pkg::NORM_BITS-1:0] m_normal_x,
    input logic signed [plc_pkg::NORM_BITS-1:0] m_normal_y,
    input logic signed [plc_pkg::NORM_BITS-1:0] m_normal_z,
    input logic [plc_pkg::PEN_BITS-1:0]         m_penetration,
    input logic [plc_pkg::REST_BITS-1:0]        m_contact_restitution
);

    `PLC_ASSERT_RST(a_reset_empty, !aresetn, !m_valid)
    `PLC_ASSERT_NXT(a_hold_valid, m_valid && !m_ready, m_valid)
    `PLC_ASSERT_IMP(a_no_contact_zero, m_valid && !m_has_contact, m_penetration == '0 && m_normal_x == '0 && m_normal_y == '0 && m_normal_z == '0 && m_contact_restitution == '0)
    `PLC_ASSERT_IMP(a_normal_range, m_valid, m_normal_x <= 16'sd16384 && m_normal_x >= -16'sd16384 && m_normal_y <= 16'sd16384 && m_normal_y >= -16'sd16384 && m_normal_z <= 16'sd16384 && m_normal_z >= -16'sd16384)

endmodule

bind particle_link_contact_unit plc_checker u_plc_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_has_contact         (m_has_contact),
    .m_normal_x            (m_normal_x),
    .m_normal_y            (m_normal_y),
    .m_normal_z            (m_normal_z),
    .m_penetration         (m_penetration),
    .m_contact_restitution (m_contact_restitution)
);
